FILE: rtl/dfpa_pkg.sv
// ----------------------------------------------------------------------------
// dfpa_pkg
// Shared types, codes and decimal constant tables for the decimal
// fixed-point accumulator.
// ----------------------------------------------------------------------------
package dfpa_pkg;

   localparam int FIELD_INT_W = 48;
   localparam int FRAC_W      = 30;
   localparam int PREC_W      = 4;
   localparam int KIND_W      = 3;
   localparam int PEND_W      = 3;
   localparam int ACT_W       = 2;
   localparam int WORK_INT_W  = 64;
   localparam int RECIP_W     = 33;
   localparam int MID_DEPTH   = 4;
   localparam int RSP_DEPTH   = 2;

   // input item kinds
   localparam logic [KIND_W-1:0] KIND_LOAD   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ADD    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_SUB    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_MUL    = 3'd4;
   localparam logic [KIND_W-1:0] KIND_DIV    = 3'd5;
   localparam logic [KIND_W-1:0] KIND_ASSIGN = 3'd6;

   // pending operation codes
   localparam logic [PEND_W-1:0] PEND_ASSIGN = 3'd0;
   localparam logic [PEND_W-1:0] PEND_ADD    = 3'd1;
   localparam logic [PEND_W-1:0] PEND_SUB    = 3'd2;
   localparam logic [PEND_W-1:0] PEND_MUL    = 3'd3;
   localparam logic [PEND_W-1:0] PEND_DIV    = 3'd4;

   // work classes handed from front to back
   localparam logic [ACT_W-1:0] ACT_NONE        = 2'd0;
   localparam logic [ACT_W-1:0] ACT_SET_OPERAND = 2'd1;
   localparam logic [ACT_W-1:0] ACT_RUN         = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0]             kind;
      logic signed [FIELD_INT_W-1:0] load_int;
      logic [FRAC_W-1:0]             load_frac;
      logic [PREC_W-1:0]             load_prec;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_INT_W-1:0] acc_int;
      logic [FRAC_W-1:0]             acc_frac;
      logic [PREC_W-1:0]             acc_prec;
      logic [PEND_W-1:0]             pending_op;
      logic signed [FIELD_INT_W-1:0] operand_int;
      logic [FRAC_W-1:0]             operand_frac;
      logic [PREC_W-1:0]             operand_prec;
   } rsp_type;

   typedef struct packed {
      logic [ACT_W-1:0]      action;
      logic [PEND_W-1:0]     new_pending;
      logic [WORK_INT_W-1:0] value_int;
      logic [FRAC_W-1:0]     value_frac;
      logic [PREC_W-1:0]     value_prec;
   } work_type;

   function automatic logic [FRAC_W-1:0] pow_ten(input logic [PREC_W-1:0] p);
      logic [FRAC_W-1:0] v;
      unique case (p)
         4'd0:    v = 30'd1;
         4'd1:    v = 30'd10;
         4'd2:    v = 30'd100;
         4'd3:    v = 30'd1000;
         4'd4:    v = 30'd10000;
         4'd5:    v = 30'd100000;
         4'd6:    v = 30'd1000000;
         4'd7:    v = 30'd10000000;
         4'd8:    v = 30'd100000000;
         4'd9:    v = 30'd1000000000;
         default: v = 30'd1;
      endcase
      return v;
   endfunction

   // floor(2^32 / 10^p); the quotient estimate is at most one low
   function automatic logic [RECIP_W-1:0] recip_ten(input logic [PREC_W-1:0] p);
      logic [RECIP_W-1:0] v;
      unique case (p)
         4'd0:    v = 33'h1_0000_0000;
         4'd1:    v = 33'd429496729;
         4'd2:    v = 33'd42949672;
         4'd3:    v = 33'd4294967;
         4'd4:    v = 33'd429496;
         4'd5:    v = 33'd42949;
         4'd6:    v = 33'd4294;
         4'd7:    v = 33'd429;
         4'd8:    v = 33'd42;
         4'd9:    v = 33'd4;
         default: v = 33'h1_0000_0000;
      endcase
      return v;
   endfunction

endpackage

FILE: rtl/decimal_fixed_point_accumulator_top.sv
// ----------------------------------------------------------------------------
// decimal_fixed_point_accumulator_top
// Calculator accumulator on decimal fixed-point values: a load/clear front,
// a two-queue split and an execute back end holding the accumulator state.
// ----------------------------------------------------------------------------
// Accepts one item per clock and returns one result per item, in order, at a
// sustained rate of one per clock while pop keeps up. An item crosses three
// front stages (fraction split by reciprocal multiply, remainder, one
// correction) and then the back end, where the accumulator update is
// combinational: scale by a power of ten, add or subtract, one carry or
// borrow. A 4-entry queue sits between front and back, and a 2-entry
// result queue lets the block keep accepting while a result waits.
// No clearing pass: the block takes items right after reset.
module decimal_fixed_point_accumulator_top #(
   parameter int INT_WIDTH = 48,
   parameter int MAX_PREC  = 9
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  dfpa_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output dfpa_pkg::rsp_type rsp_data
);
   import dfpa_pkg::*;

   logic     front_ready;
   logic     front_valid;
   work_type front_work;
   logic     mid_full;
   logic     mid_empty;
   work_type mid_work;
   logic     back_ready;
   logic     back_valid;
   rsp_type  back_rsp;
   logic     rsp_full;

   assign full = !front_ready;

   dfpa_front #(
      .MAX_PREC (MAX_PREC)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push),
      .in_ready  (front_ready),
      .in_data   (req_data),
      .out_valid (front_valid),
      .out_ready (!mid_full),
      .out_data  (front_work)
   );

   dfpa_fifo #(
      .WIDTH ($bits(work_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data (front_work),
      .full      (mid_full),
      .pop       (back_ready),
      .pop_data  (mid_work),
      .empty     (mid_empty)
   );

   dfpa_back #(
      .INT_WIDTH (INT_WIDTH),
      .MAX_PREC  (MAX_PREC)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (!mid_empty),
      .in_ready  (back_ready),
      .in_data   (mid_work),
      .out_valid (back_valid),
      .out_ready (!rsp_full),
      .out_data  (back_rsp)
   );

   dfpa_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (back_valid),
      .push_data (back_rsp),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (rsp_data),
      .empty     (empty)
   );

endmodule

FILE: rtl/dfpa_fifo.sv
// ----------------------------------------------------------------------------
// dfpa_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module dfpa_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fifo count above depth");

   a_count_push: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("fifo count missed a push");

endmodule

FILE: rtl/dfpa_front.sv
// ----------------------------------------------------------------------------
// dfpa_front
// Classifies input items and normalizes loaded values: splits an oversized
// fraction into integer carry and remainder over three pipeline stages.
// ----------------------------------------------------------------------------
module dfpa_front #(
   parameter int MAX_PREC = 9
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  dfpa_pkg::req_type  in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output dfpa_pkg::work_type out_data
);
   import dfpa_pkg::*;

   localparam int PROD_W = FRAC_W + RECIP_W;
   localparam int REM_W  = 32;

   logic                  advance;

   logic [ACT_W-1:0]      cls_action;
   logic [PEND_W-1:0]     cls_pend;
   logic [WORK_INT_W-1:0] cls_int;
   logic [FRAC_W-1:0]     cls_frac;
   logic [PREC_W-1:0]     cls_prec;

   logic                  s1_valid_ff;
   logic [ACT_W-1:0]      s1_action_ff;
   logic [PEND_W-1:0]     s1_pend_ff;
   logic [WORK_INT_W-1:0] s1_int_ff;
   logic [FRAC_W-1:0]     s1_frac_ff;
   logic [PREC_W-1:0]     s1_prec_ff;
   logic [PROD_W-1:0]     s1_prod;

   logic                  s2_valid_ff;
   logic [ACT_W-1:0]      s2_action_ff;
   logic [PEND_W-1:0]     s2_pend_ff;
   logic [WORK_INT_W-1:0] s2_int_ff;
   logic [FRAC_W-1:0]     s2_frac_ff;
   logic [PREC_W-1:0]     s2_prec_ff;
   logic [FRAC_W-1:0]     s2_quot_ff, s2_quot_in;
   logic [REM_W-1:0]      s2_back;
   logic [REM_W-1:0]      s2_rem;

   logic                  s3_valid_ff;
   logic [ACT_W-1:0]      s3_action_ff;
   logic [PEND_W-1:0]     s3_pend_ff;
   logic [WORK_INT_W-1:0] s3_int_ff;
   logic [PREC_W-1:0]     s3_prec_ff;
   logic [FRAC_W-1:0]     s3_quot_ff;
   logic [REM_W-1:0]      s3_rem_ff;
   logic [REM_W-1:0]      s3_lim;
   logic                  s3_fix;
   logic [REM_W-1:0]      s3_rem_fixed;
   logic [FRAC_W:0]       s3_quot_fixed;

   // the whole front moves together; it halts only when its last stage is blocked
   assign advance  = !s3_valid_ff || out_ready;
   assign in_ready = advance;

   always_comb begin
      cls_action = ACT_NONE;
      cls_pend   = PEND_ASSIGN;
      cls_int    = '0;
      cls_frac   = '0;
      cls_prec   = PREC_W'(MAX_PREC);
      unique case (in_data.kind)
         KIND_LOAD: begin
            cls_action = ACT_SET_OPERAND;
            cls_int    = WORK_INT_W'(in_data.load_int);
            cls_frac   = in_data.load_frac;
            cls_prec   = (in_data.load_prec > PREC_W'(MAX_PREC)) ? PREC_W'(MAX_PREC)
                                                                 : in_data.load_prec;
         end
         KIND_CLEAR: begin
            cls_action = ACT_SET_OPERAND;
         end
         KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV: begin
            cls_action = ACT_RUN;
            cls_pend   = in_data.kind - 3'd1;
         end
         KIND_ASSIGN: begin
            cls_action = ACT_RUN;
            cls_pend   = PEND_ASSIGN;
         end
         default: begin
            cls_action = ACT_NONE;
         end
      endcase
   end

   // stage 1: quotient estimate by reciprocal multiply
   assign s1_prod    = PROD_W'(s1_frac_ff) * PROD_W'(recip_ten(s1_prec_ff));
   assign s2_quot_in = s1_prod[32 +: FRAC_W];

   // stage 2: remainder of the estimate, below twice the divisor
   assign s2_back = REM_W'(s2_quot_ff) * REM_W'(pow_ten(s2_prec_ff));
   assign s2_rem  = REM_W'(s2_frac_ff) - s2_back;

   // stage 3: one correction step, then fold the quotient into the integer part
   assign s3_lim        = REM_W'(pow_ten(s3_prec_ff));
   assign s3_fix        = (s3_rem_ff >= s3_lim);
   assign s3_rem_fixed  = s3_fix ? s3_rem_ff - s3_lim : s3_rem_ff;
   assign s3_quot_fixed = (FRAC_W + 1)'(s3_quot_ff) + (FRAC_W + 1)'(s3_fix);

   assign out_valid            = s3_valid_ff;
   assign out_data.action      = s3_action_ff;
   assign out_data.new_pending = s3_pend_ff;
   assign out_data.value_int   = s3_int_ff + WORK_INT_W'(s3_quot_fixed);
   assign out_data.value_frac  = s3_rem_fixed[FRAC_W-1:0];
   assign out_data.value_prec  = s3_prec_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_action_ff <= cls_action;
         s1_pend_ff   <= cls_pend;
         s1_int_ff    <= cls_int;
         s1_frac_ff   <= cls_frac;
         s1_prec_ff   <= cls_prec;

         s2_action_ff <= s1_action_ff;
         s2_pend_ff   <= s1_pend_ff;
         s2_int_ff    <= s1_int_ff;
         s2_frac_ff   <= s1_frac_ff;
         s2_prec_ff   <= s1_prec_ff;
         s2_quot_ff   <= s2_quot_in;

         s3_action_ff <= s2_action_ff;
         s3_pend_ff   <= s2_pend_ff;
         s3_int_ff    <= s2_int_ff;
         s3_prec_ff   <= s2_prec_ff;
         s3_quot_ff   <= s2_quot_ff;
         s3_rem_ff    <= s2_rem;
      end
   end

endmodule

FILE: rtl/dfpa_back.sv
// ----------------------------------------------------------------------------
// dfpa_back
// Holds the accumulator, operand and pending operation; executes one
// classified item per cycle while out_ready holds; emits the resulting state.
// ----------------------------------------------------------------------------
module dfpa_back #(
   parameter int INT_WIDTH = 48,
   parameter int MAX_PREC  = 9
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  dfpa_pkg::work_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output dfpa_pkg::rsp_type  out_data
);
   import dfpa_pkg::*;

   localparam int SCL_W = 32;

   logic                 fire;

   logic [INT_WIDTH-1:0] acc_int_ff, acc_int_in;
   logic [FRAC_W-1:0]    acc_frac_ff, acc_frac_in;
   logic [PREC_W-1:0]    acc_prec_ff, acc_prec_in;
   logic [INT_WIDTH-1:0] operand_int_ff, operand_int_in;
   logic [FRAC_W-1:0]    operand_frac_ff, operand_frac_in;
   logic [PREC_W-1:0]    operand_prec_ff, operand_prec_in;
   logic [PEND_W-1:0]    pending_ff, pending_in;

   logic [PREC_W-1:0]    prec_max;
   logic [SCL_W-1:0]     acc_scaled;
   logic [SCL_W-1:0]     opd_scaled;
   logic [SCL_W-1:0]     lim;
   logic [SCL_W-1:0]     sum;
   logic                 carry;
   logic                 borrow;
   logic [SCL_W-1:0]     add_frac;
   logic [SCL_W-1:0]     sub_frac;
   logic [INT_WIDTH-1:0] add_int;
   logic [INT_WIDTH-1:0] sub_int;
   logic [WORK_INT_W-1:0] acc_int_wide;
   logic [WORK_INT_W-1:0] operand_int_wide;

   assign fire      = in_valid && out_ready;
   assign in_ready  = out_ready;
   assign out_valid = in_valid;

   // both fractions brought to the finer precision; each stays below 10^prec_max
   assign prec_max   = (acc_prec_ff > operand_prec_ff) ? acc_prec_ff : operand_prec_ff;
   assign acc_scaled = SCL_W'(acc_frac_ff) * SCL_W'(pow_ten(prec_max - acc_prec_ff));
   assign opd_scaled = SCL_W'(operand_frac_ff) * SCL_W'(pow_ten(prec_max - operand_prec_ff));
   assign lim        = SCL_W'(pow_ten(prec_max));

   assign sum      = acc_scaled + opd_scaled;
   assign carry    = (sum >= lim);
   assign borrow   = (acc_scaled < opd_scaled);
   assign add_frac = carry ? sum - lim : sum;
   assign sub_frac = borrow ? acc_scaled + lim - opd_scaled : acc_scaled - opd_scaled;
   assign add_int  = acc_int_ff + operand_int_ff + INT_WIDTH'(carry);
   assign sub_int  = acc_int_ff - operand_int_ff - INT_WIDTH'(borrow);

   always_comb begin
      acc_int_in      = acc_int_ff;
      acc_frac_in     = acc_frac_ff;
      acc_prec_in     = acc_prec_ff;
      operand_int_in  = operand_int_ff;
      operand_frac_in = operand_frac_ff;
      operand_prec_in = operand_prec_ff;
      pending_in      = pending_ff;
      if (fire) begin
         unique case (in_data.action)
            ACT_SET_OPERAND: begin
               operand_int_in  = in_data.value_int[INT_WIDTH-1:0];
               operand_frac_in = in_data.value_frac;
               operand_prec_in = in_data.value_prec;
            end
            ACT_RUN: begin
               pending_in = in_data.new_pending;
               unique case (pending_ff)
                  PEND_ASSIGN: begin
                     acc_int_in  = operand_int_ff;
                     acc_frac_in = operand_frac_ff;
                     acc_prec_in = operand_prec_ff;
                  end
                  PEND_ADD: begin
                     acc_int_in  = add_int;
                     acc_frac_in = add_frac[FRAC_W-1:0];
                     acc_prec_in = prec_max;
                  end
                  PEND_SUB: begin
                     acc_int_in  = sub_int;
                     acc_frac_in = sub_frac[FRAC_W-1:0];
                     acc_prec_in = prec_max;
                  end
                  default: begin
                     // mul and div are recorded but never carried out
                     acc_int_in = acc_int_ff;
                  end
               endcase
            end
            default: begin
               pending_in = pending_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_int_ff      <= '0;
         acc_frac_ff     <= '0;
         acc_prec_ff     <= PREC_W'(MAX_PREC);
         operand_int_ff  <= '0;
         operand_frac_ff <= '0;
         operand_prec_ff <= PREC_W'(MAX_PREC);
         pending_ff      <= PEND_ASSIGN;
      end else begin
         acc_int_ff      <= acc_int_in;
         acc_frac_ff     <= acc_frac_in;
         acc_prec_ff     <= acc_prec_in;
         operand_int_ff  <= operand_int_in;
         operand_frac_ff <= operand_frac_in;
         operand_prec_ff <= operand_prec_in;
         pending_ff      <= pending_in;
      end
   end

   assign acc_int_wide     = WORK_INT_W'($signed(acc_int_in));
   assign operand_int_wide = WORK_INT_W'($signed(operand_int_in));

   assign out_data.acc_int      = acc_int_wide[FIELD_INT_W-1:0];
   assign out_data.acc_frac     = acc_frac_in;
   assign out_data.acc_prec     = acc_prec_in;
   assign out_data.pending_op   = pending_in;
   assign out_data.operand_int  = operand_int_wide[FIELD_INT_W-1:0];
   assign out_data.operand_frac = operand_frac_in;
   assign out_data.operand_prec = operand_prec_in;

   a_acc_frac_range: assert property (@(posedge clock) disable iff (reset)
      SCL_W'(acc_frac_ff) < SCL_W'(pow_ten(acc_prec_ff)))
      else $error("accumulator fraction not below ten to its precision");

   a_opd_frac_range: assert property (@(posedge clock) disable iff (reset)
      SCL_W'(operand_frac_ff) < SCL_W'(pow_ten(operand_prec_ff)))
      else $error("operand fraction not below ten to its precision");

   a_prec_range: assert property (@(posedge clock) disable iff (reset)
      (acc_prec_ff <= PREC_W'(MAX_PREC)) && (operand_prec_ff <= PREC_W'(MAX_PREC)))
      else $error("precision above maximum");

   a_mul_div_hold: assert property (@(posedge clock) disable iff (reset)
      (fire && (in_data.action == ACT_RUN) &&
       ((pending_ff == PEND_MUL) || (pending_ff == PEND_DIV)))
      |=> ($stable(acc_int_ff) && $stable(acc_frac_ff) && $stable(acc_prec_ff)))
      else $error("pending mul or div changed the accumulator");

endmodule

FILE: tb/sv/dfpa_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dfpa_checker
// Watches both queue ports of the decimal accumulator, keeps its own copy of
// the accumulator, operand and pending operation, and compares every result
// transfer field by field with the snapshot predicted for the oldest
// accepted item.
// ----------------------------------------------------------------------------
module dfpa_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic              full,
   input  dfpa_pkg::req_type req_data,
   input  logic              empty,
   input  logic              pop,
   input  dfpa_pkg::rsp_type rsp_data,
   output int                mismatch_count,
   output int                checked_count,
   output int                due_count
);
   import dfpa_pkg::*;

   localparam int MAX_P = 9;

   typedef struct packed {
      logic [47:0] whole;   // two's complement, wraps
      logic [63:0] frac;
      logic [3:0]  prec;
   } dec_value_type;

   dec_value_type     acc_val;
   dec_value_type     operand_val;
   logic [PEND_W-1:0] pending;
   rsp_type           calc_snapshots[$];

   initial begin
      mismatch_count = 0;
      checked_count  = 0;
      due_count      = 0;
   end

   function automatic logic [63:0] ten_to(input logic [3:0] p);
      logic [63:0] v;
      v = 64'd1;
      for (int i = 0; i < p; i++)
         v = v * 64'd10;
      return v;
   endfunction

   // both fractions scaled to the finer precision, then one carry or borrow
   function automatic dec_value_type add_sub(input dec_value_type x,
                                             input dec_value_type y,
                                             input logic minus);
      dec_value_type r;
      logic [3:0]    p;
      logic [63:0]   a;
      logic [63:0]   b;
      logic [63:0]   span;
      p    = (x.prec > y.prec) ? x.prec : y.prec;
      a    = x.frac * ten_to(p - x.prec);
      b    = y.frac * ten_to(p - y.prec);
      span = ten_to(p);
      r.prec = p;
      if (!minus) begin
         r.whole = x.whole + y.whole;
         r.frac  = a + b;
         if (r.frac >= span) begin
            r.frac  = r.frac - span;
            r.whole = r.whole + 48'd1;
         end
      end else begin
         r.whole = x.whole - y.whole;
         if (a >= b) begin
            r.frac = a - b;
         end else begin
            r.frac  = a + span - b;
            r.whole = r.whole - 48'd1;
         end
      end
      return r;
   endfunction

   function automatic rsp_type advance_calculator(input req_type item);
      rsp_type     r;
      logic [3:0]  p;
      logic [63:0] span;
      unique case (item.kind)
         KIND_LOAD: begin
            p    = (item.load_prec > MAX_P) ? 4'(MAX_P) : item.load_prec;
            span = ten_to(p);
            // fraction digits at or above one whole unit spill into the integer
            operand_val.whole = item.load_int + 48'(64'(item.load_frac) / span);
            operand_val.frac  = 64'(item.load_frac) % span;
            operand_val.prec  = p;
         end
         KIND_CLEAR: begin
            operand_val      = '0;
            operand_val.prec = 4'(MAX_P);
         end
         KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV, KIND_ASSIGN: begin
            unique case (pending)
               PEND_ASSIGN: acc_val = operand_val;
               PEND_ADD:    acc_val = add_sub(acc_val, operand_val, 1'b0);
               PEND_SUB:    acc_val = add_sub(acc_val, operand_val, 1'b1);
               default:     ;   // mul and div never do anything
            endcase
            unique case (item.kind)
               KIND_ADD: pending = PEND_ADD;
               KIND_SUB: pending = PEND_SUB;
               KIND_MUL: pending = PEND_MUL;
               KIND_DIV: pending = PEND_DIV;
               default:  pending = PEND_ASSIGN;
            endcase
         end
         default: ;   // unused kind leaves everything alone
      endcase
      r.acc_int      = acc_val.whole;
      r.acc_frac     = acc_val.frac[FRAC_W-1:0];
      r.acc_prec     = acc_val.prec;
      r.pending_op   = pending;
      r.operand_int  = operand_val.whole;
      r.operand_frac = operand_val.frac[FRAC_W-1:0];
      r.operand_prec = operand_val.prec;
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatch_count < 40)
         $display("[%0t] MISMATCH on result %0d: %s", $time, checked_count, what);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         acc_val          = '0;
         acc_val.prec     = 4'(MAX_P);
         operand_val      = '0;
         operand_val.prec = 4'(MAX_P);
         pending          = PEND_ASSIGN;
         calc_snapshots.delete();
      end else begin
         if (push && !full)
            calc_snapshots.push_back(advance_calculator(req_data));
         if (pop && !empty) begin
            checked_count++;
            if (calc_snapshots.size() == 0) begin
               report_mismatch("result transfer with nothing outstanding");
            end else begin
               want = calc_snapshots.pop_front();
               if (rsp_data.acc_int !== want.acc_int)
                  report_mismatch($sformatf("acc_int got %0h want %0h",
                                            rsp_data.acc_int, want.acc_int));
               if (rsp_data.acc_frac !== want.acc_frac)
                  report_mismatch($sformatf("acc_frac got %0d want %0d",
                                            rsp_data.acc_frac, want.acc_frac));
               if (rsp_data.acc_prec !== want.acc_prec)
                  report_mismatch($sformatf("acc_prec got %0d want %0d",
                                            rsp_data.acc_prec, want.acc_prec));
               if (rsp_data.pending_op !== want.pending_op)
                  report_mismatch($sformatf("pending_op got %0d want %0d",
                                            rsp_data.pending_op, want.pending_op));
               if (rsp_data.operand_int !== want.operand_int)
                  report_mismatch($sformatf("operand_int got %0h want %0h",
                                            rsp_data.operand_int, want.operand_int));
               if (rsp_data.operand_frac !== want.operand_frac)
                  report_mismatch($sformatf("operand_frac got %0d want %0d",
                                            rsp_data.operand_frac, want.operand_frac));
               if (rsp_data.operand_prec !== want.operand_prec)
                  report_mismatch($sformatf("operand_prec got %0d want %0d",
                                            rsp_data.operand_prec, want.operand_prec));
            end
         end
      end
      due_count <= calc_snapshots.size();
   end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the decimal accumulator with a directed opener covering wrap,
// carry, borrow, precision saturation, fraction spill and every kind, then
// random load/operation sequences mixed with noise items. The sender works
// in bursts and the receiver stalls in changing patterns; the checker
// beside the block does the predicting and comparing.
// ----------------------------------------------------------------------------
module tb_top;
   import dfpa_pkg::*;

   localparam int                ITEM_TARGET  = 500;
   localparam int                DRAIN_CYCLES = 20;
   localparam logic [KIND_W-1:0] KIND_UNUSED  = 3'd7;

   logic        clock    = 1'b0;
   logic        reset    = 1'b1;
   logic        push     = 1'b0;
   logic        pop      = 1'b0;
   req_type     req_data = '0;
   logic        full;
   logic        empty;
   rsp_type     rsp_data;
   int          mismatch_count;
   int          checked_count;
   int          due_count;
   logic [15:0] pop_tick = '0;
   req_type     plan[$];
   int          kind_tally[8];

   decimal_fixed_point_accumulator_top #(
      .INT_WIDTH(48),
      .MAX_PREC (9)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .full    (full),
      .req_data(req_data),
      .empty   (empty),
      .pop     (pop),
      .rsp_data(rsp_data)
   );

   dfpa_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_data      (req_data),
      .empty         (empty),
      .pop           (pop),
      .rsp_data      (rsp_data),
      .mismatch_count(mismatch_count),
      .checked_count (checked_count),
      .due_count     (due_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // the receiver's stall pattern changes with bits 8:7 of pop_tick
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         pop_tick <= pop_tick + 16'd1;
         case (pop_tick[8:7])
            2'd0:    pop <= 1'b1;
            2'd1:    pop <= ($urandom_range(0, 1) == 0);
            2'd2:    pop <= (pop_tick[2:0] == 3'd0);
            default: pop <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   function automatic req_type noise_item();
      req_type r;
      r.kind      = 3'($urandom);
      r.load_int  = {$urandom, 16'($urandom)};
      r.load_frac = 30'($urandom);
      r.load_prec = 4'($urandom);
      return r;
   endfunction

   function automatic req_type make_op(input logic [KIND_W-1:0] kind);
      req_type r;
      r      = noise_item();   // load fields are don't-care here
      r.kind = kind;
      return r;
   endfunction

   function automatic req_type make_load(input logic [47:0] whole,
                                         input logic [29:0] frac,
                                         input logic [3:0]  prec);
      req_type r;
      r.kind      = KIND_LOAD;
      r.load_int  = whole;
      r.load_frac = frac;
      r.load_prec = prec;
      return r;
   endfunction

   function automatic req_type random_load();
      logic [47:0] whole;
      logic [29:0] frac;
      logic [3:0]  prec;
      logic [31:0] span;
      case ($urandom_range(0, 5))
         0:       whole = 48'h7FFF_FFFF_FFFF - 48'($urandom_range(0, 2));
         1:       whole = 48'h8000_0000_0000 + 48'($urandom_range(0, 2));
         2:       whole = 48'($urandom_range(0, 40)) - 48'd20;
         default: whole = {$urandom, 16'($urandom)};
      endcase
      prec = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(10, 15))
                                         : 4'($urandom_range(0, 9));
      span = 32'd1;
      repeat ((prec > 4'd9) ? 9 : prec) span = span * 32'd10;
      case ($urandom_range(0, 7))
         0:       frac = '0;
         1:       frac = 30'(span - 32'd1);
         2:       frac = 30'($urandom);   // may spill into the integer
         default: frac = 30'($urandom_range(0, span - 32'd1));
      endcase
      return make_load(whole, frac, prec);
   endfunction

   function automatic logic [KIND_W-1:0] pick_op();
      case ($urandom_range(0, 9))
         0, 1, 2: return KIND_ADD;
         3, 4, 5: return KIND_SUB;
         6:       return KIND_MUL;
         7:       return KIND_DIV;
         default: return KIND_ASSIGN;
      endcase
   endfunction

   initial begin
      req_type item;
      int      burst;
      int      gap;

      plan.push_back(make_load(48'h7FFF_FFFF_FFFF, 30'd999_999_999, 4'd9));
      plan.push_back(make_op(KIND_ADD));      // pending assign copies the operand
      plan.push_back(make_load(48'd0, 30'd1, 4'd9));
      plan.push_back(make_op(KIND_SUB));      // carry wraps to most negative
      plan.push_back(make_load(48'd0, 30'd5, 4'd1));
      plan.push_back(make_op(KIND_MUL));      // borrow wraps back to most positive
      plan.push_back(make_load(48'h8000_0000_0000, 30'h3FFF_FFFF, 4'd15));
      plan.push_back(make_op(KIND_DIV));      // mul pending: no change
      plan.push_back(make_op(KIND_CLEAR));
      plan.push_back(make_op(KIND_ASSIGN));   // div pending: no change
      plan.push_back(make_op(KIND_UNUSED));
      plan.push_back(make_op(KIND_ASSIGN));   // copies the cleared operand
      plan.push_back(make_load(48'hFFFF_FFFF_FFFF, 30'd0, 4'd0));
      plan.push_back(make_op(KIND_ADD));
      plan.push_back(make_load(48'd0, 30'd123, 4'd3));
      plan.push_back(make_op(KIND_SUB));      // add across precisions 0 and 3
      plan.push_back(make_load(48'd3, 30'd999, 4'd2));
      plan.push_back(make_op(KIND_ASSIGN));   // sub with scaling and borrow
      plan.push_back(make_load(48'd0, 30'd7, 4'd0));
      plan.push_back(make_op(KIND_ADD));
      plan.push_back(make_load(48'd1, 30'd999_999_999, 4'd9));
      plan.push_back(make_op(KIND_ASSIGN));   // precision 0 plus precision 9

      while (plan.size() < 22 + ITEM_TARGET) begin
         if ($urandom_range(0, 9) < 2) begin
            plan.push_back(noise_item());
         end else begin
            plan.push_back(($urandom_range(0, 7) == 0) ? make_op(KIND_CLEAR)
                                                        : random_load());
            plan.push_back(make_op(pick_op()));
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (plan.size() > 0) begin
         burst = $urandom_range(1, 40);
         while (burst > 0 && plan.size() > 0) begin
            item = plan.pop_front();
            kind_tally[item.kind]++;
            push     <= 1'b1;
            req_data <= item;
            @(posedge clock);
            while (full) @(posedge clock);
            burst--;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            push     <= 1'b0;
            req_data <= noise_item();
            repeat (gap) @(posedge clock);
         end
      end
      push <= 1'b0;

      @(posedge clock);
      while (due_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d loads, %0d clears, %0d add/sub, %0d mul/div, %0d assign, %0d unused",
               kind_tally[KIND_LOAD], kind_tally[KIND_CLEAR],
               kind_tally[KIND_ADD] + kind_tally[KIND_SUB],
               kind_tally[KIND_MUL] + kind_tally[KIND_DIV],
               kind_tally[KIND_ASSIGN], kind_tally[KIND_UNUSED]);
      $display("Compared %0d result transfers, %0d field mismatches",
               checked_count, mismatch_count);
      if (mismatch_count == 0 && due_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timeout: run did not drain");
      $display("*** FAILED ***");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/dfpa_pkg.sv
rtl/dfpa_fifo.sv
rtl/dfpa_front.sv
rtl/dfpa_back.sv
rtl/decimal_fixed_point_accumulator_top.sv
tb/sv/dfpa_checker.sv
tb/sv/tb_top.sv
